[design/rdfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rdfp_pkg;

  localparam int LINE_W   = 10;
  localparam int DELAY_W  = 8;
  localparam int REPEAT_W = 4;
  localparam int POS_W    = 24;
  localparam int BYTE_W   = 8;
  localparam int CSEL_W   = 2;
  localparam int CREG_W   = 4;

  // Register bytes below this value address a chip register.
  localparam int CHIP_REGS = 48;
  // Bit of the register byte that closes a frame.
  localparam int END_BIT = 7;

  localparam int CFG_W     = POS_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LINES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SKIP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_REPEAT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SONG_LENGTH  = 2'd3;

  localparam logic [LINE_W-1:0] SCAN_LINES_RST = 10'd311;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Item kinds, shared by the input command and the result kind.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_PAIR = 1'b1;

  // Steps of the bit-serial line fold (width of the unfolded sum).
  localparam int DIV_STEPS = LINE_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic                kind;
    logic [LINE_W-1:0]   next_line;
    logic                frame_request;
    logic                write_valid;
    logic [CSEL_W-1:0]   chip_select;
    logic [CREG_W-1:0]   chip_register;
    logic [BYTE_W-1:0]   chip_data;
    logic                frame_end;
    logic                song_done;
  } out_item_t;

endpackage

`default_nettype wire

[design/rdfp_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rdfp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [rdfp_pkg::BYTE_W-1:0]   pair_value;
  logic [rdfp_pkg::BYTE_W-1:0]   pair_register;

  modport source (output valid, output cmd, output pair_value, output pair_register,
                  input ready);
  modport sink (input valid, input cmd, input pair_value, input pair_register,
                output ready);
endinterface

`default_nettype wire

[design/rdfp_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rdfp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [rdfp_pkg::LINE_W-1:0]   next_line;
  logic                          frame_request;
  logic                          write_valid;
  logic [rdfp_pkg::CSEL_W-1:0]   chip_select;
  logic [rdfp_pkg::CREG_W-1:0]   chip_register;
  logic [rdfp_pkg::BYTE_W-1:0]   chip_data;
  logic                          frame_end;
  logic                          song_done;

  modport source (output valid, output kind, output next_line, output frame_request,
                  output write_valid, output chip_select, output chip_register,
                  output chip_data, output frame_end, output song_done,
                  input ready);
  modport sink (input valid, input kind, input next_line, input frame_request,
                input write_valid, input chip_select, input chip_register,
                input chip_data, input frame_end, input song_done,
                output ready);
endinterface

`default_nettype wire

[design/register_dump_frame_player.sv]
// Register dump frame player.
// in_ch carries ticks (cmd = 0) and register pairs (cmd = 1); out_ch gives
// exactly one result per input item, in order. A transfer happens on a rising
// clk edge with valid and ready both high. cfg_we/cfg_index/cfg_data write the
// scan_lines, line_skip, frame_repeat and song_length registers; write them
// only while no item is in flight.
// Each result is registered in the output register or the skid entry. A tick
// whose line sum lies beyond twice scan_lines needs a full fold, done by a
// bit-serial remainder unit, one bit per cycle, and in_ch.ready stays low
// until the fold is done. Ticks with line_skip <= scan_lines and all pairs
// sustain one item per cycle while out_ch keeps taking results.
// The result side is a two-entry queue (output register plus skid), so an item
// is still taken while one result waits; in_ch.ready drops when both entries
// are full or the fold unit is busy. in_ch.ready is decoded from registers
// only and does not follow out_ch.ready in the same cycle.
// Reset (rst_n low, synchronous) empties the queue, clears the player state
// and loads the register defaults (scan_lines = 311, all others 0).
`timescale 1ns / 1ps
`default_nettype none

module register_dump_frame_player #(
  parameter int CHIP_REGS = rdfp_pkg::CHIP_REGS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  rdfp_in_if.sink                              in_ch,
  rdfp_out_if.source                           out_ch,
  input  wire                                  cfg_we,
  input  wire [rdfp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [rdfp_pkg::CFG_W-1:0]            cfg_data
);

  localparam int LW = rdfp_pkg::LINE_W;
  // delay product width: value byte times (frame_repeat + 1)
  localparam int PW = rdfp_pkg::BYTE_W + rdfp_pkg::REPEAT_W + 1;

  // configuration registers
  logic [LW-1:0]                     scan_lines_r;
  logic [LW-1:0]                     line_skip_r;
  logic [rdfp_pkg::REPEAT_W-1:0]     frame_repeat_r;
  logic [rdfp_pkg::POS_W-1:0]        song_length_r;

  // player state
  logic [LW-1:0]                     line_pos_r;
  logic [rdfp_pkg::DELAY_W-1:0]      frame_delay_r;
  logic                              frame_open_r;
  logic [rdfp_pkg::POS_W-1:0]        byte_pos_r;
  logic                              done_r;

  // bit-serial fold unit
  logic                              busy_r;
  logic [rdfp_pkg::DIV_CNT_W-1:0]    div_cnt_r;
  logic [LW:0]                       div_num_r;
  logic [LW-1:0]                     div_rem_r;
  logic                              pend_req_r;
  logic                              pend_done_r;

  // result queue
  rdfp_pkg::out_item_t               out_r;
  rdfp_pkg::out_item_t               skid_r;
  logic                              out_valid_r;
  logic                              skid_valid_r;

  logic                              in_fire;
  logic                              is_tick;
  logic [LW:0]                       tick_sum;
  logic [LW:0]                       tick_diff;
  logic [LW:0]                       scan_ext;
  logic                              tick_slow;
  logic [LW-1:0]                     tick_line;
  logic [rdfp_pkg::POS_W:0]          pos_next;
  logic                              pos_hit;
  logic [PW-1:0]                     delay_prod;
  logic [rdfp_pkg::DELAY_W-1:0]      delay_new;
  logic                              chip_hit;
  logic                              end_hit;
  rdfp_pkg::out_item_t               res;
  rdfp_pkg::out_item_t               fin;
  rdfp_pkg::out_item_t               push_item;
  logic [LW:0]                       rem_sh;
  logic [LW-1:0]                     rem_step;
  logic                              div_last;
  logic                              push;
  logic                              pop;

  assign in_ch.ready = !busy_r && !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_tick     = (in_ch.cmd == rdfp_pkg::KIND_TICK);

  // Line fold: one subtraction covers sums up to twice scan_lines; anything
  // further goes through the remainder unit.
  assign scan_ext  = {1'b0, scan_lines_r};
  assign tick_sum  = {1'b0, line_pos_r} + {1'b0, line_skip_r};
  assign tick_diff = tick_sum - scan_ext;

  always_comb begin
    tick_slow = 1'b0;
    tick_line = tick_sum[LW-1:0];
    if (scan_lines_r == '0) begin
      tick_line = tick_sum[LW-1:0];
    end else if (tick_sum <= scan_ext) begin
      tick_line = tick_sum[LW-1:0];
    end else if (tick_diff <= scan_ext) begin
      tick_line = tick_diff[LW-1:0];
    end else begin
      tick_slow = 1'b1;
    end
  end

  // Pair path
  assign pos_next   = {1'b0, byte_pos_r} + (rdfp_pkg::POS_W+1)'(2);
  assign pos_hit    = (pos_next >= {1'b0, song_length_r});
  assign delay_prod = PW'(in_ch.pair_value) * PW'({1'b0, frame_repeat_r} + 5'd1);
  assign delay_new  = delay_prod[rdfp_pkg::DELAY_W-1:0] - 8'd1;
  assign chip_hit   = (in_ch.pair_register < 8'(CHIP_REGS));
  assign end_hit    = in_ch.pair_register[rdfp_pkg::END_BIT];

  always_comb begin
    res = '0;
    res.song_done = done_r;
    if (is_tick) begin
      res.kind          = rdfp_pkg::KIND_TICK;
      res.next_line     = tick_line;
      res.frame_request = (frame_delay_r == '0);
    end else begin
      res.kind = rdfp_pkg::KIND_PAIR;
      if (frame_open_r) begin
        res.song_done = done_r || pos_hit;
        res.frame_end = end_hit;
        if (chip_hit) begin
          res.write_valid   = 1'b1;
          res.chip_select   = in_ch.pair_register[5:4];
          res.chip_register = in_ch.pair_register[3:0];
          res.chip_data     = in_ch.pair_value;
        end
      end
    end
  end

  // One restoring remainder step on (sum - 1) mod scan_lines.
  assign rem_sh   = {div_rem_r, div_num_r[LW]};
  assign rem_step = (rem_sh >= scan_ext) ? LW'(rem_sh - scan_ext) : rem_sh[LW-1:0];
  assign div_last = busy_r && (div_cnt_r == rdfp_pkg::DIV_CNT_W'(rdfp_pkg::DIV_STEPS - 1));

  always_comb begin
    fin               = '0;
    fin.kind          = rdfp_pkg::KIND_TICK;
    fin.next_line     = rem_step + LW'(1);
    fin.frame_request = pend_req_r;
    fin.song_done     = pend_done_r;
  end

  assign push      = (in_fire && !(is_tick && tick_slow)) || div_last;
  assign push_item = div_last ? fin : res;
  assign pop       = out_valid_r && out_ch.ready;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_lines_r   <= rdfp_pkg::SCAN_LINES_RST;
      line_skip_r    <= '0;
      frame_repeat_r <= '0;
      song_length_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdfp_pkg::CFG_SCAN_LINES:   scan_lines_r   <= cfg_data[LW-1:0];
        rdfp_pkg::CFG_LINE_SKIP:    line_skip_r    <= cfg_data[LW-1:0];
        rdfp_pkg::CFG_FRAME_REPEAT: frame_repeat_r <= cfg_data[rdfp_pkg::REPEAT_W-1:0];
        rdfp_pkg::CFG_SONG_LENGTH:  song_length_r  <= cfg_data[rdfp_pkg::POS_W-1:0];
      endcase
    end
  end

  // player state and fold unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r    <= '0;
      frame_delay_r <= '0;
      frame_open_r  <= 1'b0;
      byte_pos_r    <= '0;
      done_r        <= 1'b0;
      busy_r        <= 1'b0;
      div_cnt_r     <= '0;
    end else begin
      if (in_fire) begin
        if (is_tick) begin
          if (tick_slow) begin
            busy_r      <= 1'b1;
            div_cnt_r   <= '0;
            div_num_r   <= tick_sum - (LW+1)'(1);
            div_rem_r   <= '0;
            pend_req_r  <= (frame_delay_r == '0);
            pend_done_r <= done_r;
          end else begin
            line_pos_r <= tick_line;
          end
          if (frame_delay_r != '0) begin
            frame_delay_r <= frame_delay_r - 8'd1;
          end else begin
            frame_open_r <= 1'b1;
          end
        end else if (frame_open_r) begin
          if (pos_hit) begin
            done_r <= 1'b1;
          end
          byte_pos_r <= pos_next[rdfp_pkg::POS_W] ? rdfp_pkg::POS_MAX
                                                  : pos_next[rdfp_pkg::POS_W-1:0];
          if (end_hit) begin
            frame_delay_r <= delay_new;
            frame_open_r  <= 1'b0;
          end
        end
      end
      if (busy_r) begin
        div_rem_r <= rem_step;
        div_num_r <= {div_num_r[LW-1:0], 1'b0};
        div_cnt_r <= div_cnt_r + rdfp_pkg::DIV_CNT_W'(1);
        if (div_last) begin
          busy_r     <= 1'b0;
          line_pos_r <= fin.next_line;
        end
      end
    end
  end

  // two-entry result queue; pushes only happen while the skid entry is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r       <= push_item;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= push_item;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_r.kind;
  assign out_ch.next_line     = out_r.next_line;
  assign out_ch.frame_request = out_r.frame_request;
  assign out_ch.write_valid   = out_r.write_valid;
  assign out_ch.chip_select   = out_r.chip_select;
  assign out_ch.chip_register = out_r.chip_register;
  assign out_ch.chip_data     = out_r.chip_data;
  assign out_ch.frame_end     = out_r.frame_end;
  assign out_ch.song_done     = out_r.song_done;

endmodule

`default_nettype wire
